// ===== hdl/stkeng_pkg.sv =====
// Shared types and codes for the stack engine.
`default_nettype none
package stkeng_pkg;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned DEPTH_W = 7;

  localparam logic [FUNC_W-1:0] FUNC_PUSH    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DUP     = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SWAP    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_REVERSE = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FEW   = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [WORD_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [DEPTH_W-1:0]       depth;
    logic                     top_valid;
    logic signed [WORD_W-1:0] top_value;
  } out_word_t;

  typedef enum logic [1:0] {RA_LO, RA_HI} raddr_sel_e;
  typedef enum logic [1:0] {WA_LO, WA_HI, WA_CNT} waddr_sel_e;
  typedef enum logic [1:0] {WD_VALUE, WD_RDATA, WD_HOLD} wdata_sel_e;
  typedef enum logic [2:0] {PTR_HOLD, PTR_REV, PTR_SWAP, PTR_TOP, PTR_STEP} ptr_op_e;

  typedef struct packed {
    logic       value_ld;
    logic       rd_en;
    raddr_sel_e ra_sel;
    logic       wr_en;
    waddr_sel_e wa_sel;
    wdata_sel_e wd_sel;
    logic       hold_ld;
    ptr_op_e    ptr_op;
    logic       cnt_inc;
    logic       cnt_dec;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic few;
    logic full;
    logic pair_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/stack_engine_push_pop_dup_swap_reverse.sv =====
// Top level of the stack engine: controller plus datapath.
// Per word: decode, single-port memory accesses (one read or write per cycle),
// then a top read-back. Push writes, pop lowers the count, dup copies the top,
// swap flips the top pair, reverse of n entries flips floor(n/2) pairs; refused and
// unknown codes skip memory. Only idle takes a word; busy holds until done_o.
// Reset (rst_ni low, async) empties the stack; memory contents are not cleared.
// done_o is a one-cycle strobe; the receiver cannot stall it.
`default_nettype none
module stack_engine_push_pop_dup_swap_reverse #(
  parameter int unsigned DEPTH = 64
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start,
  input  wire stkeng_pkg::in_word_t  cmd_i,
  output logic                       busy,
  output logic                       done_o,
  output stkeng_pkg::out_word_t      result_o
);

  // Command and status between controller and datapath.
  stkeng_pkg::dp_cmd_t  dp_cmd;
  stkeng_pkg::dp_stat_t dp_stat;

  logic [1:0]                           status;
  logic [stkeng_pkg::DEPTH_W-1:0]       depth;
  logic                                 top_valid;
  logic signed [stkeng_pkg::WORD_W-1:0] top_value;

  // Sequencer: decides refusals, walks swap/reverse pairs, reads back the top.
  stkeng_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .func_i   (cmd_i.func),
    .stat_i   (dp_stat),
    .cmd_o    (dp_cmd),
    .busy     (busy),
    .done_o   (done_o),
    .status_o (status)
  );

  // Stack memory, entry count and the lo/hi pair pointers.
  stkeng_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .value_i     (cmd_i.value),
    .stat_o      (dp_stat),
    .depth_o     (depth),
    .top_valid_o (top_valid),
    .top_value_o (top_value)
  );

  // Result word, all fields from registers; valid while done_o is high.
  always_comb begin
    result_o.status    = status;
    result_o.depth     = depth;
    result_o.top_valid = top_valid;
    result_o.top_value = top_value;
  end

endmodule
`default_nettype wire

// ===== hdl/stkeng_dp.sv =====
// Datapath: stack memory, count, walk pointers and top readout.
`default_nettype none
module stkeng_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire stkeng_pkg::dp_cmd_t               cmd_i,
  input  wire logic signed [stkeng_pkg::WORD_W-1:0] value_i,
  output stkeng_pkg::dp_stat_t                   stat_o,
  output logic [stkeng_pkg::DEPTH_W-1:0]         depth_o,
  output logic                                   top_valid_o,
  output logic signed [stkeng_pkg::WORD_W-1:0]   top_value_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [stkeng_pkg::WORD_W-1:0] mem [DEPTH];

  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0] cnt_m1, cnt_m2, raddr, waddr;
  logic [AW:0]   span;
  logic [stkeng_pkg::WORD_W-1:0] value_q, hold_q, rdata_q, wdata;

  assign cnt_m1 = AW'(cnt_q - CW'(1));
  assign cnt_m2 = AW'(cnt_q - CW'(2));
  assign span   = {1'b0, hi_q} - {1'b0, lo_q};

  assign stat_o.empty     = (cnt_q == '0);
  assign stat_o.few       = (cnt_q < CW'(2));
  assign stat_o.full      = (cnt_q == CW'(DEPTH));
  assign stat_o.pair_last = (span <= (AW + 1)'(2));

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    case (cmd_i.ptr_op)
      stkeng_pkg::PTR_REV: begin
        lo_d = '0;
        hi_d = cnt_m1;
      end
      stkeng_pkg::PTR_SWAP: begin
        lo_d = cnt_m2;
        hi_d = cnt_m1;
      end
      stkeng_pkg::PTR_TOP: begin
        hi_d = cnt_m1;
      end
      stkeng_pkg::PTR_STEP: begin
        lo_d = lo_q + AW'(1);
        hi_d = hi_q - AW'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    raddr = (cmd_i.ra_sel == stkeng_pkg::RA_LO) ? lo_q : hi_q;
    case (cmd_i.wa_sel)
      stkeng_pkg::WA_LO: waddr = lo_q;
      stkeng_pkg::WA_HI: waddr = hi_q;
      default:           waddr = cnt_q[AW-1:0];
    endcase
    case (cmd_i.wd_sel)
      stkeng_pkg::WD_VALUE: wdata = value_q;
      stkeng_pkg::WD_RDATA: wdata = rdata_q;
      default:              wdata = hold_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      lo_q  <= '0;
      hi_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      lo_q  <= lo_d;
      hi_q  <= hi_d;
    end
  end

  // Payload and memory: no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.value_ld) begin
      value_q <= value_i;
    end
    if (cmd_i.hold_ld) begin
      hold_q <= rdata_q;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
    if (cmd_i.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  assign depth_o     = stkeng_pkg::DEPTH_W'(cnt_q);
  assign top_valid_o = (cnt_q != '0);
  assign top_value_o = top_valid_o ? signed'(rdata_q) : '0;

endmodule
`default_nettype wire

// ===== hdl/stkeng_ctrl.sv =====
// Controller: sequences memory accesses for each operation.
`default_nettype none
module stkeng_ctrl (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start,
  input  wire logic [stkeng_pkg::FUNC_W-1:0] func_i,
  input  wire stkeng_pkg::dp_stat_t          stat_i,
  output stkeng_pkg::dp_cmd_t                cmd_o,
  output logic                               busy,
  output logic                               done_o,
  output logic [1:0]                         status_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_DUP_RD, S_DUP_WR, S_RD_LO, S_RD_HI,
    S_WR_LO, S_WR_HI, S_TOP_PTR, S_TOP_RD, S_RESP
  } state_e;

  state_e state_q, state_d;
  logic [1:0] status_q, status_d;
  logic [stkeng_pkg::FUNC_W-1:0] func_q, func_d;
  logic busy_q, done_q;

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    func_d   = func_q;

    cmd_o.value_ld = 1'b0;
    cmd_o.rd_en    = 1'b0;
    cmd_o.ra_sel   = stkeng_pkg::RA_HI;
    cmd_o.wr_en    = 1'b0;
    cmd_o.wa_sel   = stkeng_pkg::WA_CNT;
    cmd_o.wd_sel   = stkeng_pkg::WD_VALUE;
    cmd_o.hold_ld  = 1'b0;
    cmd_o.ptr_op   = stkeng_pkg::PTR_HOLD;
    cmd_o.cnt_inc  = 1'b0;
    cmd_o.cnt_dec  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.value_ld = 1'b1;
          func_d  = func_i;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        status_d = stkeng_pkg::ST_OK;
        state_d  = S_TOP_PTR;
        unique case (func_q)
          stkeng_pkg::FUNC_PUSH: begin
            if (stat_i.full) begin
              status_d = stkeng_pkg::ST_FULL;
            end else begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.cnt_inc = 1'b1;
            end
          end
          stkeng_pkg::FUNC_POP: begin
            if (stat_i.empty) begin
              status_d = stkeng_pkg::ST_EMPTY;
            end else begin
              cmd_o.cnt_dec = 1'b1;
            end
          end
          stkeng_pkg::FUNC_DUP: begin
            if (stat_i.empty) begin
              status_d = stkeng_pkg::ST_EMPTY;
            end else if (stat_i.full) begin
              status_d = stkeng_pkg::ST_FULL;
            end else begin
              cmd_o.ptr_op = stkeng_pkg::PTR_TOP;
              state_d      = S_DUP_RD;
            end
          end
          stkeng_pkg::FUNC_SWAP: begin
            if (stat_i.few) begin
              status_d = stkeng_pkg::ST_FEW;
            end else begin
              cmd_o.ptr_op = stkeng_pkg::PTR_SWAP;
              state_d      = S_RD_LO;
            end
          end
          stkeng_pkg::FUNC_REVERSE: begin
            if (stat_i.few) begin
              status_d = stkeng_pkg::ST_FEW;
            end else begin
              cmd_o.ptr_op = stkeng_pkg::PTR_REV;
              state_d      = S_RD_LO;
            end
          end
          default: begin
          end
        endcase
      end
      S_DUP_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_DUP_WR;
      end
      S_DUP_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wd_sel  = stkeng_pkg::WD_RDATA;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_TOP_PTR;
      end
      S_RD_LO: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.ra_sel = stkeng_pkg::RA_LO;
        state_d      = S_RD_HI;
      end
      S_RD_HI: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.hold_ld = 1'b1;
        state_d       = S_WR_LO;
      end
      S_WR_LO: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wa_sel = stkeng_pkg::WA_LO;
        cmd_o.wd_sel = stkeng_pkg::WD_RDATA;
        state_d      = S_WR_HI;
      end
      S_WR_HI: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wa_sel = stkeng_pkg::WA_HI;
        cmd_o.wd_sel = stkeng_pkg::WD_HOLD;
        cmd_o.ptr_op = stkeng_pkg::PTR_STEP;
        state_d      = stat_i.pair_last ? S_TOP_PTR : S_RD_LO;
      end
      S_TOP_PTR: begin
        cmd_o.ptr_op = stkeng_pkg::PTR_TOP;
        state_d      = S_TOP_RD;
      end
      S_TOP_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= stkeng_pkg::ST_OK;
      func_q   <= stkeng_pkg::FUNC_PUSH;
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      func_q   <= func_d;
      busy_q   <= (state_d != S_IDLE);
      done_q   <= (state_d == S_RESP);
    end
  end

  assign busy     = busy_q;
  assign done_o   = done_q;
  assign status_o = status_q;

endmodule
`default_nettype wire

// ===== hdl/stkeng_chk.sv =====
// Port-level checker for the stack engine, bound to the top level.
`default_nettype none
module stkeng_chk (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        start,
  input wire                        busy,
  input wire                        done_o,
  input wire stkeng_pkg::out_word_t result_o
);

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe while not busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted word did not raise busy");

  a_done_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!busy && !done_o))
    else $error("busy not released after result");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.top_valid) |-> (result_o.top_value == '0))
    else $error("empty stack reports nonzero top");

endmodule

bind stack_engine_push_pop_dup_swap_reverse stkeng_chk u_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
`default_nettype wire
